// ----- sv/stq_pkg.sv -----
// Shared constants, command codes and the front-to-back command record.
package stq_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int TREE_NODES   = 2048;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int NODE_W       = 11;
    localparam int VAL_W        = 32;
    localparam int STK_DEPTH    = 16;
    localparam int STK_W        = 4;
    localparam logic signed [VAL_W-1:0] LARGEST_VALUE = 32'sh7fff_ffff;
    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic KIND_WRITE = 1'b0;

    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_WRITE_SKIP  = 2'd1,
        OP_QUERY       = 2'd2,
        OP_QUERY_EMPTY = 2'd3
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [IDX_W-1:0]         first;
        logic [IDX_W-1:0]         last;
        logic [IDX_W-1:0]         top;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;
endpackage

// ----- sv/stq_front.sv -----
// Request intake: element count register, range clipping, command queue.
module stq_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_kind,
    input  logic [stq_pkg::IDX_W-1:0] i_first_index,
    input  logic [stq_pkg::IDX_W-1:0] i_last_index,
    input  logic signed [stq_pkg::VAL_W-1:0] i_value,
    input  logic                      i_cfg_valid,
    input  logic [stq_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_clearing,
    output logic                      o_cmd_valid,
    output stq_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_take
);
    import stq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] top_w;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] last_clip;
    t_cmd             cmd_in;
    t_cmd             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;

    always_comb begin
        used = r_count;
        if (r_count == '0) begin
            used = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_ELEMENTS)) begin
            used = CNT_W'(MAX_ELEMENTS);
        end
        top_w     = used - CNT_W'(1);
        top       = top_w[IDX_W-1:0];
        last_clip = (i_last_index > top) ? top : i_last_index;
        cmd_in.first = i_first_index;
        cmd_in.last  = last_clip;
        cmd_in.top   = top;
        cmd_in.value = i_value;
        if (i_kind == KIND_WRITE) begin
            cmd_in.op = (i_first_index <= top) ? OP_WRITE : OP_WRITE_SKIP;
        end else begin
            cmd_in.op = (i_first_index > last_clip) ? OP_QUERY_EMPTY : OP_QUERY;
        end
    end

    assign o_full      = (r_cnt == 2'd2) || i_clearing;
    assign do_push     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(i_cmd_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cmd_in;
        end
    end
endmodule

// ----- sv/stq_back.sv -----
// Tree engine: node memory, clear sweep, update and query sequencer, result queue.
module stq_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    output logic                      o_clearing,
    input  logic                      i_cmd_valid,
    input  stq_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_take,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [stq_pkg::VAL_W-1:0] o_minimum,
    output logic                      o_range_empty
);
    import stq_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_WDESC = 8'b0000_0100,
        S_WRD   = 8'b0000_1000,
        S_WWR   = 8'b0001_0000,
        S_ROOT  = 8'b0010_0000,
        S_QRUN  = 8'b0100_0000,
        S_QFIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [VAL_W-1:0] r_mem [TREE_NODES];
    logic signed [VAL_W-1:0] r_rd0, r_rd1;
    logic                    we;
    logic [NODE_W-1:0]       wa, ra0, ra1;
    logic signed [VAL_W-1:0] wd;

    logic [NODE_W-1:0] r_clr, n_clr;
    logic [NODE_W-1:0] r_node, n_node;
    logic [IDX_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic [IDX_W-1:0]  r_l, n_l, r_r, n_r;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic signed [VAL_W-1:0] r_acc, n_acc;
    logic              r_pend, n_pend;

    logic [NODE_W-1:0] r_sn [STK_DEPTH];
    logic [IDX_W-1:0]  r_slo [STK_DEPTH];
    logic [IDX_W-1:0]  r_shi [STK_DEPTH];
    logic [STK_W:0]    r_sp, n_sp;
    logic              s_we0, s_we1;
    logic [STK_W-1:0]  s_a0, s_a1;
    logic [NODE_W-1:0] s_n0, s_n1;
    logic [IDX_W-1:0]  s_lo0, s_hi0, s_lo1, s_hi1;
    logic [STK_W:0]    sp_m1;
    logic [NODE_W-1:0] t_node;
    logic [IDX_W-1:0]  t_lo, t_hi;

    logic [IDX_W:0]    sum;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W:0]    qsum;
    logic [IDX_W-1:0]  qmid;
    logic signed [VAL_W-1:0] cmin;

    logic                    res_push;
    logic signed [VAL_W-1:0] res_min;
    logic                    res_emp;
    logic signed [VAL_W-1:0] r_oq_min [2];
    logic                    r_oq_emp [2];
    logic                    r_owp, r_orp;
    logic [1:0]              r_ocnt;
    logic                    do_pop;

    assign o_clearing    = (r_state == S_CLEAR);
    assign o_empty       = (r_ocnt == 2'd0);
    assign do_pop        = i_pop && !o_empty;
    assign o_minimum     = r_oq_min[r_orp];
    assign o_range_empty = r_oq_emp[r_orp];

    assign sp_m1  = r_sp - (STK_W+1)'(1);
    assign t_node = r_sn[sp_m1[STK_W-1:0]];
    assign t_lo   = r_slo[sp_m1[STK_W-1:0]];
    assign t_hi   = r_shi[sp_m1[STK_W-1:0]];
    assign sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid    = sum[IDX_W:1];
    assign qsum   = {1'b0, t_lo} + {1'b0, t_hi};
    assign qmid   = qsum[IDX_W:1];
    assign cmin   = (r_rd0 < r_rd1) ? r_rd0 : r_rd1;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_node  = r_node;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_l     = r_l;
        n_r     = r_r;
        n_val   = r_val;
        n_acc   = r_acc;
        n_pend  = 1'b0;
        n_sp    = r_sp;
        we      = 1'b0;
        wa      = r_node;
        wd      = r_val;
        ra0     = r_node;
        ra1     = r_node;
        s_we0   = 1'b0;
        s_we1   = 1'b0;
        s_a0    = sp_m1[STK_W-1:0];
        s_a1    = r_sp[STK_W-1:0];
        s_n0    = t_node;
        s_lo0   = t_lo;
        s_hi0   = t_hi;
        s_n1    = t_node;
        s_lo1   = t_lo;
        s_hi1   = t_hi;
        o_cmd_take = 1'b0;
        res_push = 1'b0;
        res_min  = r_acc;
        res_emp  = 1'b0;
        if (r_pend && (r_rd0 < r_acc)) begin
            n_acc = r_rd0;
        end
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                wd    = LARGEST_VALUE;
                n_clr = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(TREE_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ra0 = NODE_W'(1);
                if (i_cmd_valid && (r_ocnt != 2'd2)) begin
                    o_cmd_take = 1'b1;
                    n_node = NODE_W'(1);
                    n_lo   = '0;
                    n_hi   = i_cmd.top;
                    n_l    = i_cmd.first;
                    n_r    = i_cmd.last;
                    n_val  = i_cmd.value;
                    case (i_cmd.op)
                        OP_WRITE: begin
                            n_state = S_WDESC;
                        end
                        OP_WRITE_SKIP: begin
                            n_state = S_ROOT;
                        end
                        OP_QUERY: begin
                            n_acc   = LARGEST_VALUE;
                            s_we0   = 1'b1;
                            s_a0    = '0;
                            s_n0    = NODE_W'(1);
                            s_lo0   = '0;
                            s_hi0   = i_cmd.top;
                            n_sp    = (STK_W+1)'(1);
                            n_state = S_QRUN;
                        end
                        default: begin
                            res_push = 1'b1;
                            res_min  = LARGEST_VALUE;
                            res_emp  = 1'b1;
                        end
                    endcase
                end
            end
            S_WDESC: begin
                if (r_lo == r_hi) begin
                    we = 1'b1;
                    if (r_node == NODE_W'(1)) begin
                        res_push = 1'b1;
                        res_min  = r_val;
                        n_state  = S_IDLE;
                    end else begin
                        n_node  = r_node >> 1;
                        n_state = S_WRD;
                    end
                end else if (r_l <= mid) begin
                    n_node = {r_node[NODE_W-2:0], 1'b0};
                    n_hi   = mid;
                end else begin
                    n_node = {r_node[NODE_W-2:0], 1'b1};
                    n_lo   = mid + IDX_W'(1);
                end
            end
            S_WRD: begin
                ra0     = {r_node[NODE_W-2:0], 1'b0};
                ra1     = {r_node[NODE_W-2:0], 1'b1};
                n_state = S_WWR;
            end
            S_WWR: begin
                we = 1'b1;
                wd = cmin;
                if (r_node == NODE_W'(1)) begin
                    res_push = 1'b1;
                    res_min  = cmin;
                    n_state  = S_IDLE;
                end else begin
                    n_node  = r_node >> 1;
                    n_state = S_WRD;
                end
            end
            S_ROOT: begin
                res_push = 1'b1;
                res_min  = r_rd0;
                n_state  = S_IDLE;
            end
            S_QRUN: begin
                if (r_sp == '0) begin
                    n_state = S_QFIN;
                end else if ((r_r < t_lo) || (t_hi < r_l)) begin
                    n_sp = sp_m1;
                end else if ((r_l <= t_lo) && (t_hi <= r_r)) begin
                    ra0    = t_node;
                    n_pend = 1'b1;
                    n_sp   = sp_m1;
                end else begin
                    s_we0 = 1'b1;
                    s_n0  = {t_node[NODE_W-2:0], 1'b1};
                    s_lo0 = qmid + IDX_W'(1);
                    s_hi0 = t_hi;
                    s_we1 = 1'b1;
                    s_n1  = {t_node[NODE_W-2:0], 1'b0};
                    s_lo1 = t_lo;
                    s_hi1 = qmid;
                    n_sp  = r_sp + (STK_W+1)'(1);
                end
            end
            S_QFIN: begin
                res_push = 1'b1;
                res_min  = r_acc;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_clear) begin
            n_state  = S_CLEAR;
            n_clr    = '0;
            we       = 1'b0;
            res_push = 1'b0;
            o_cmd_take = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_sp    <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_sp    <= n_sp;
            if (res_push) begin
                r_owp <= ~r_owp;
            end
            if (do_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(res_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_l    <= n_l;
        r_r    <= n_r;
        r_val  <= n_val;
        r_acc  <= n_acc;
        if (s_we0) begin
            r_sn[s_a0]  <= s_n0;
            r_slo[s_a0] <= s_lo0;
            r_shi[s_a0] <= s_hi0;
        end
        if (s_we1) begin
            r_sn[s_a1]  <= s_n1;
            r_slo[s_a1] <= s_lo1;
            r_shi[s_a1] <= s_hi1;
        end
        if (res_push) begin
            r_oq_min[r_owp] <= res_min;
            r_oq_emp[r_owp] <= res_emp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd0 <= r_mem[ra0];
        r_rd1 <= r_mem[ra1];
    end
endmodule

// ----- sv/segment_tree_range_minimum.sv -----
// Top level: segment tree range minimum engine.
// Keeps a tree of minima over up to 1024 signed 32-bit elements held in a
// 2048-entry node memory with one write and two read ports. A write request
// descends one level at a time to its leaf and then refreshes each ancestor,
// reading its two children and then writing their minimum; a query request
// walks the tree with a node stack and visits one node per cycle. One
// request is worked on at a time; up to two wait in the intake queue and two
// results in the result queue. After reset and after every element count
// write the node memory is swept to the largest value, during which full
// stays high.
module segment_tree_range_minimum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_kind,
    input  logic [stq_pkg::IDX_W-1:0] i_first_index,
    input  logic [stq_pkg::IDX_W-1:0] i_last_index,
    input  logic signed [stq_pkg::VAL_W-1:0] i_value,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [stq_pkg::VAL_W-1:0] o_minimum,
    output logic                      o_range_empty,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [stq_pkg::CNT_W-1:0] i_cfg_data
);
    import stq_pkg::*;

    logic clearing;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;
    logic cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    stq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .i_value       (i_value),
        .i_cfg_valid   (cfg_write),
        .i_cfg_data    (i_cfg_data),
        .i_clearing    (clearing),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    stq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (cfg_write),
        .o_clearing    (clearing),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_take    (cmd_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_minimum     (o_minimum),
        .o_range_empty (o_range_empty)
    );
endmodule
